// ----- rtl/lde_pkg.sv -----
// Package for the linked deque engine: sizes, codes and controller state type.
package lde_pkg;
   localparam int Capacity   = 64;
   localparam int SlotWidth  = $clog2(Capacity);
   localparam int LinkWidth  = SlotWidth + 1;
   localparam int ValueWidth = 32;
   localparam int CountWidth = 7;

   typedef enum logic [2:0] {
      REQ_PUSH_FRONT = 3'd0, REQ_PUSH_REAR = 3'd1, REQ_POP_FRONT = 3'd2,
      REQ_POP_REAR = 3'd3, REQ_INS_AFTER = 3'd4, REQ_INS_BEFORE = 3'd5,
      REQ_DELETE = 3'd6, REQ_NONE = 3'd7
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_NOKEY = 2'd2, ST_FULL = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECIDE, S_SEARCH_RD, S_SEARCH_CMP, S_UNLINK_RD, S_UNLINK_WR,
      S_LINK_RD, S_LINK_WR, S_ENDS_RD, S_ENDS_WAIT, S_RESPOND
   } state_type;

   localparam logic [LinkWidth-1:0] NilSlot = LinkWidth'(Capacity);

   // Command from controller to datapath.
   typedef struct packed {
      logic       load;       // capture request
      logic       decide;     // compute first status
      logic       search_rd;  // read node at cursor
      logic       search_cmp; // compare and advance
      logic       unlink_rd;  // read links of victim
      logic       unlink_wr;  // splice victim out
      logic       link_rd;    // read neighbour link for insert
      logic       link_wr;    // write new node
      logic       ends_rd;    // read head and tail values
      logic       ends_cap;   // capture head and tail values
      logic       set_nokey;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic       done_early; // status decided, no change
      logic       is_delete;  // unlink path
      logic       needs_search;
      logic       found;
      logic       exhausted;
   } stat_type;
endpackage

// ----- rtl/lde_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface lde_req_if (input logic clock);
   logic                             valid;
   logic                             ready;
   logic [2:0]                       req_type;
   logic signed [lde_pkg::ValueWidth-1:0] key_value;
   logic signed [lde_pkg::ValueWidth-1:0] new_value;
   modport source (output valid, req_type, key_value, new_value, input ready);
   modport sink (input valid, req_type, key_value, new_value, output ready);
endinterface

interface lde_rsp_if (input logic clock);
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic [lde_pkg::CountWidth-1:0]   item_count;
   logic signed [lde_pkg::ValueWidth-1:0] front_value;
   logic signed [lde_pkg::ValueWidth-1:0] rear_value;
   modport source (output valid, status, item_count, front_value, rear_value,
                   input ready);
   modport sink (input valid, status, item_count, front_value, rear_value,
                 output ready);
endinterface

// ----- rtl/linked_deque_engine.sv -----
// Top level of the linked deque engine: controller plus datapath.
// The engine holds a doubly linked deque of up to 64 signed 32-bit values.
// Requests arrive on the req channel (valid/ready); each request carries an
// operation code, a key and a new value. Exactly one response leaves on the
// rsp channel for each request, with the status, the length after the
// request, and the front and rear values (zero when the list is empty).
// One request is handled at a time. A push passes through the decide, link
// read, link write, ends read and ends wait states before the response is
// offered; a pop takes the unlink read and write states in place of the link
// ones. Key requests visit the list one node at a time (a registered read of
// the node, then the compare), visiting at most 64 nodes. Requests settled
// without any change (empty list, full store, unused code) go from decide
// straight to the ends states, and a missing key after its search. After the
// response is taken the engine returns to idle, where it accepts the next request.
// The response register holds its contents while the receiver stalls; no
// new request is accepted until the response has been taken.
// Reset is synchronous and empties the list at once: every slot is marked
// free and no clearing pass is needed, since slot contents are only read
// once written. Duplicate keys resolve to the first match from the front.
module linked_deque_engine (
   input logic clock,
   input logic reset,
   lde_req_if.sink   req,
   lde_rsp_if.source rsp
);
   lde_pkg::cmd_type  cmd;
   lde_pkg::stat_type stat;

   lde_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .stat
   );

   lde_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .in_type(req.req_type), .in_key(req.key_value), .in_new(req.new_value),
      .out_status(rsp.status), .out_count(rsp.item_count),
      .out_front(rsp.front_value), .out_rear(rsp.rear_value)
   );
endmodule

// ----- rtl/lde_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
module lde_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lde_pkg::cmd_type   cmd,
   input  lde_pkg::stat_type  stat
);
   lde_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= lde_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lde_pkg::S_IDLE: if (req_valid) state_in = lde_pkg::S_DECIDE;
         lde_pkg::S_DECIDE: begin
            if (stat.done_early) state_in = lde_pkg::S_ENDS_RD;
            else if (stat.needs_search) state_in = lde_pkg::S_SEARCH_RD;
            else if (stat.is_delete) state_in = lde_pkg::S_UNLINK_RD;
            else state_in = lde_pkg::S_LINK_RD;
         end
         lde_pkg::S_SEARCH_RD: state_in = lde_pkg::S_SEARCH_CMP;
         lde_pkg::S_SEARCH_CMP: begin
            if (stat.found) begin
               if (stat.is_delete) state_in = lde_pkg::S_UNLINK_RD;
               else state_in = lde_pkg::S_LINK_RD;
            end else if (stat.exhausted) state_in = lde_pkg::S_ENDS_RD;
            else state_in = lde_pkg::S_SEARCH_RD;
         end
         lde_pkg::S_UNLINK_RD: state_in = lde_pkg::S_UNLINK_WR;
         lde_pkg::S_UNLINK_WR: state_in = lde_pkg::S_ENDS_RD;
         lde_pkg::S_LINK_RD: state_in = lde_pkg::S_LINK_WR;
         lde_pkg::S_LINK_WR: state_in = lde_pkg::S_ENDS_RD;
         lde_pkg::S_ENDS_RD: state_in = lde_pkg::S_ENDS_WAIT;
         lde_pkg::S_ENDS_WAIT: state_in = lde_pkg::S_RESPOND;
         lde_pkg::S_RESPOND: if (rsp_ready) state_in = lde_pkg::S_IDLE;
         default: state_in = lde_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         lde_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         lde_pkg::S_DECIDE: cmd.decide = 1'b1;
         lde_pkg::S_SEARCH_RD: cmd.search_rd = 1'b1;
         lde_pkg::S_SEARCH_CMP: begin
            cmd.search_cmp = 1'b1;
            cmd.set_nokey = !stat.found && stat.exhausted;
         end
         lde_pkg::S_UNLINK_RD: cmd.unlink_rd = 1'b1;
         lde_pkg::S_UNLINK_WR: cmd.unlink_wr = 1'b1;
         lde_pkg::S_LINK_RD: cmd.link_rd = 1'b1;
         lde_pkg::S_LINK_WR: cmd.link_wr = 1'b1;
         lde_pkg::S_ENDS_RD: cmd.ends_rd = 1'b1;
         lde_pkg::S_ENDS_WAIT: cmd.ends_cap = 1'b1;
         lde_pkg::S_RESPOND: rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

// ----- rtl/lde_datapath.sv -----
// Datapath: slot memories, free map, head, tail, count and result registers.
module lde_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lde_pkg::cmd_type                      cmd,
   output lde_pkg::stat_type                     stat,
   input  logic [2:0]                            in_type,
   input  logic signed [lde_pkg::ValueWidth-1:0] in_key,
   input  logic signed [lde_pkg::ValueWidth-1:0] in_new,
   output logic [1:0]                            out_status,
   output logic [lde_pkg::CountWidth-1:0]        out_count,
   output logic signed [lde_pkg::ValueWidth-1:0] out_front,
   output logic signed [lde_pkg::ValueWidth-1:0] out_rear
);
   localparam int SW = lde_pkg::SlotWidth;
   localparam int LW = lde_pkg::LinkWidth;
   localparam int VW = lde_pkg::ValueWidth;
   localparam int CW = lde_pkg::CountWidth;
   localparam int N  = lde_pkg::Capacity;

   // Value memory reads the search cursor, or head and tail at once.
   logic [VW-1:0] val_mem [N];
   logic [LW-1:0] next_mem [N];
   logic [LW-1:0] prev_mem [N];

   logic [N-1:0]  free_ff;
   logic [LW-1:0] head_ff, tail_ff;
   logic [CW-1:0] count_ff;
   logic [2:0]    type_ff;
   logic [VW-1:0] key_ff, new_ff;
   logic [1:0]    status_ff;
   logic [LW-1:0] cur_ff;      // search cursor
   logic [CW-1:0] steps_ff;
   logic [LW-1:0] found_ff;
   logic [SW-1:0] alloc_ff;
   logic [VW-1:0] rd_val_ff, rd_a_ff, rd_b_ff;
   logic [LW-1:0] rd_next_ff, rd_prev_ff;
   logic [VW-1:0] front_ff, rear_ff;
   logic          found_flag;

   wire is_add = (type_ff == lde_pkg::REQ_PUSH_FRONT) || (type_ff == lde_pkg::REQ_PUSH_REAR)
              || (type_ff == lde_pkg::REQ_INS_AFTER) || (type_ff == lde_pkg::REQ_INS_BEFORE);
   wire is_key = (type_ff == lde_pkg::REQ_INS_AFTER) || (type_ff == lde_pkg::REQ_INS_BEFORE)
              || (type_ff == lde_pkg::REQ_DELETE);
   wire is_pop = (type_ff == lde_pkg::REQ_POP_FRONT) || (type_ff == lde_pkg::REQ_POP_REAR);
   wire empty  = (count_ff == '0);
   wire full   = (count_ff == CW'(N));

   // Lowest free slot, chosen by priority encoder.
   logic [SW-1:0] low_free;
   always_comb begin
      low_free = '0;
      for (int i = N - 1; i >= 0; i--) if (free_ff[i]) low_free = SW'(i);
   end

   // Link address for the link-read phase.
   logic [SW-1:0] victim;
   always_comb begin
      case (type_ff)
         lde_pkg::REQ_POP_FRONT: victim = head_ff[SW-1:0];
         lde_pkg::REQ_POP_REAR:  victim = tail_ff[SW-1:0];
         default:                victim = found_ff[SW-1:0];
      endcase
   end

   assign found_flag = (cur_ff != lde_pkg::NilSlot) && (rd_val_ff == key_ff);

   assign stat.done_early = (type_ff == lde_pkg::REQ_NONE)
                         || ((is_pop || is_key) && empty) || (is_add && full);
   assign stat.is_delete  = is_pop || (type_ff == lde_pkg::REQ_DELETE);
   assign stat.needs_search = is_key;
   assign stat.found      = found_flag;
   assign stat.exhausted  = (cur_ff == lde_pkg::NilSlot) || (steps_ff == CW'(N - 1));

   // Splice targets.
   logic [LW-1:0] p_lnk, q_lnk;
   always_comb begin
      case (type_ff)
         lde_pkg::REQ_PUSH_FRONT: begin p_lnk = lde_pkg::NilSlot; q_lnk = head_ff; end
         lde_pkg::REQ_PUSH_REAR:  begin p_lnk = tail_ff; q_lnk = lde_pkg::NilSlot; end
         lde_pkg::REQ_INS_AFTER:  begin p_lnk = found_ff; q_lnk = rd_next_ff; end
         default:                 begin p_lnk = rd_prev_ff; q_lnk = found_ff; end
      endcase
   end
   wire [LW-1:0] new_lnk = {1'b0, alloc_ff};
   wire [LW-1:0] head_nx = (count_ff == CW'(1)) ? lde_pkg::NilSlot : rd_next_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= in_type; key_ff <= in_key; new_ff <= in_new;
      end
      if (cmd.decide) begin
         cur_ff <= head_ff; steps_ff <= '0; alloc_ff <= low_free;
      end
      if (cmd.search_rd) rd_val_ff <= val_mem[cur_ff[SW-1:0]];
      if (cmd.search_rd) rd_next_ff <= next_mem[cur_ff[SW-1:0]];
      if (cmd.search_cmp) begin
         found_ff <= cur_ff;
         cur_ff <= rd_next_ff;
         steps_ff <= steps_ff + CW'(1);
      end
      if (cmd.unlink_rd || cmd.link_rd) begin
         rd_next_ff <= next_mem[victim];
         rd_prev_ff <= prev_mem[victim];
      end
      if (cmd.unlink_wr) begin
         if (rd_prev_ff != lde_pkg::NilSlot) next_mem[rd_prev_ff[SW-1:0]] <= rd_next_ff;
         if (rd_next_ff != lde_pkg::NilSlot) prev_mem[rd_next_ff[SW-1:0]] <= rd_prev_ff;
      end
      if (cmd.link_wr) begin
         val_mem[alloc_ff] <= new_ff;
         next_mem[alloc_ff] <= (p_lnk != lde_pkg::NilSlot) && (p_lnk[SW-1:0] == alloc_ff)
                               ? q_lnk : q_lnk;
         prev_mem[alloc_ff] <= p_lnk;
         if (p_lnk != lde_pkg::NilSlot) next_mem[p_lnk[SW-1:0]] <= new_lnk;
         if (q_lnk != lde_pkg::NilSlot) prev_mem[q_lnk[SW-1:0]] <= new_lnk;
      end
      if (cmd.ends_rd) begin
         rd_a_ff <= val_mem[head_ff[SW-1:0]];
         rd_b_ff <= val_mem[tail_ff[SW-1:0]];
      end
      if (cmd.ends_cap) begin
         front_ff <= (head_ff == lde_pkg::NilSlot) ? '0 : rd_a_ff;
         rear_ff  <= (tail_ff == lde_pkg::NilSlot) ? '0 : rd_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1; head_ff <= lde_pkg::NilSlot; tail_ff <= lde_pkg::NilSlot;
         count_ff <= '0; status_ff <= lde_pkg::ST_OK;
      end else begin
         if (cmd.decide) begin
            if (type_ff == lde_pkg::REQ_NONE) status_ff <= lde_pkg::ST_OK;
            else if ((is_pop || is_key) && empty) status_ff <= lde_pkg::ST_EMPTY;
            else if (is_add && full) status_ff <= lde_pkg::ST_FULL;
            else status_ff <= lde_pkg::ST_OK;
         end
         if (cmd.set_nokey) status_ff <= lde_pkg::ST_NOKEY;
         if (cmd.unlink_wr) begin
            free_ff[victim] <= 1'b1;
            count_ff <= count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               head_ff <= lde_pkg::NilSlot; tail_ff <= lde_pkg::NilSlot;
            end else begin
               if (rd_prev_ff == lde_pkg::NilSlot) head_ff <= head_nx;
               if (rd_next_ff == lde_pkg::NilSlot) tail_ff <= rd_prev_ff;
            end
         end
         if (cmd.link_wr) begin
            free_ff[alloc_ff] <= 1'b0;
            count_ff <= count_ff + CW'(1);
            if (p_lnk == lde_pkg::NilSlot) head_ff <= new_lnk;
            if (q_lnk == lde_pkg::NilSlot) tail_ff <= new_lnk;
         end
      end
   end

   assign out_status = status_ff;
   assign out_count  = count_ff;
   assign out_front  = front_ff;
   assign out_rear   = rear_ff;
endmodule

// ----- rtl/lde_checker.sv -----
// Port-level checker for the linked deque engine, bound to the top level.
module lde_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lde_pkg::CountWidth-1:0]  item_count,
   input logic signed [lde_pkg::ValueWidth-1:0] front_value
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(item_count))
      else $error("response dropped");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> item_count <= 7'(lde_pkg::Capacity)) else $error("count overflow");
   a_emp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_count == '0 |-> front_value == '0) else $error("empty front");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("response too early");
endmodule

bind linked_deque_engine lde_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .item_count(rsp.item_count), .front_value(rsp.front_value)
);

// ----- tb/lde_tb_pkg.sv -----
// Scoreboard class for the linked deque engine testbench.
package lde_tb_pkg;
   import lde_pkg::*;

   typedef struct {
      logic [1:0]             status;
      logic [CountWidth-1:0]  item_count;
      logic [ValueWidth-1:0]  front_value;
      logic [ValueWidth-1:0]  rear_value;
   } deque_rsp_type;

   class deque_scoreboard;
      // Mirror of the list, front at index 0.
      logic [ValueWidth-1:0] list_values[$];
      deque_rsp_type         pending_rsps[$];
      int                    mismatches;

      function void clear();
         list_values.delete();
         pending_rsps.delete();
         mismatches = 0;
      endfunction

      function int find_first(logic [ValueWidth-1:0] key);
         foreach (list_values[i])
            if (list_values[i] == key) return i;
         return -1;
      endfunction

      function void note_request(logic [2:0] code, logic [ValueWidth-1:0] key,
                                 logic [ValueWidth-1:0] value);
         deque_rsp_type r;
         int            pos;
         logic          adds;
         r.status = ST_OK;
         adds = code inside {REQ_PUSH_FRONT, REQ_PUSH_REAR, REQ_INS_AFTER, REQ_INS_BEFORE};
         if (code == REQ_NONE) begin
         end else if (code != REQ_PUSH_FRONT && code != REQ_PUSH_REAR &&
                      list_values.size() == 0) begin
            r.status = ST_EMPTY;
         end else if (adds && list_values.size() >= Capacity) begin
            r.status = ST_FULL;
         end else begin
            case (code)
               REQ_PUSH_FRONT: list_values.push_front(value);
               REQ_PUSH_REAR:  list_values.push_back(value);
               REQ_POP_FRONT:  void'(list_values.pop_front());
               REQ_POP_REAR:   void'(list_values.pop_back());
               default: begin
                  pos = find_first(key);
                  if (pos < 0) r.status = ST_NOKEY;
                  else if (code == REQ_INS_AFTER) list_values.insert(pos + 1, value);
                  else if (code == REQ_INS_BEFORE) list_values.insert(pos, value);
                  else list_values.delete(pos);
               end
            endcase
         end
         r.item_count = CountWidth'(list_values.size());
         r.front_value = list_values.size() ? list_values[0] : '0;
         r.rear_value = list_values.size() ? list_values[$] : '0;
         pending_rsps.push_back(r);
      endfunction

      function void report(string what, longint got, longint want);
         $display("mismatch: %s got %0h expected %0h", what, got, want);
         mismatches++;
      endfunction

      function void check_response(deque_rsp_type got);
         deque_rsp_type want;
         if (pending_rsps.size() == 0) begin
            report("response with nothing outstanding", 1, 0);
            return;
         end
         want = pending_rsps.pop_front();
         if (got.status !== want.status) report("status", got.status, want.status);
         if (got.item_count !== want.item_count)
            report("item_count", got.item_count, want.item_count);
         if (got.front_value !== want.front_value)
            report("front_value", got.front_value, want.front_value);
         if (got.rear_value !== want.rear_value)
            report("rear_value", got.rear_value, want.rear_value);
      endfunction
   endclass
endpackage

// ----- tb/tb_linked_deque_engine.sv -----
// Top level of the linked deque engine testbench: stimulus, handshakes, checks.
module tb_linked_deque_engine;
   import lde_pkg::*;
   import lde_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lde_req_if req (clock);
   lde_rsp_if rsp (clock);

   linked_deque_engine dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   deque_scoreboard board = new();
   // Idle rates in percent for the sender and the receiver; changed per phase.
   int  send_idle = 13;
   int  recv_idle = 58;
   bit  stim_done = 1'b0;
   // Values recently stored, so that key requests mostly hit.
   logic [ValueWidth-1:0] recent_values[$];

   initial begin
      req.valid = 1'b0;
      req.req_type = REQ_NONE;
      req.key_value = '0;
      req.new_value = '0;
      rsp.ready = 1'b0;
      board.clear();
   end

   // Receiver: ready changes at the falling edge, responses taken at the rising one.
   always @(negedge clock) begin
      if (!reset) rsp.ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         deque_rsp_type got;
         got.status = rsp.status;
         got.item_count = rsp.item_count;
         got.front_value = rsp.front_value;
         got.rear_value = rsp.rear_value;
         board.check_response(got);
      end
   end

   // Presents one request and holds it until the engine accepts it.
   // Called and left at a falling edge; valid stays high into the next call.
   task automatic send_request(logic [2:0] code, logic [ValueWidth-1:0] key,
                               logic [ValueWidth-1:0] value);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.req_type <= code;
      req.key_value <= key;
      req.new_value <= value;
      do @(posedge clock); while (!req.ready);
      board.note_request(code, key, value);
      if (code inside {REQ_PUSH_FRONT, REQ_PUSH_REAR, REQ_INS_AFTER, REQ_INS_BEFORE}) begin
         recent_values.push_back(value);
         if (recent_values.size() > 16) void'(recent_values.pop_front());
      end
      @(negedge clock);
   endtask

   function automatic logic [ValueWidth-1:0] pick_key();
      // Mostly a value that was stored lately; sometimes anything at all.
      if (recent_values.size() && $urandom_range(9) < 8)
         return recent_values[$urandom_range(recent_values.size() - 1)];
      return $urandom();
   endfunction

   function automatic logic [ValueWidth-1:0] pick_value();
      // A small pool makes duplicate keys common.
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return $urandom_range(7);
      endcase
   endfunction

   // Random phase; the push bias drifts so the list both fills and drains.
   task automatic random_phase(int n);
      int          bias;
      logic [2:0]  code;
      for (int i = 0; i < n; i++) begin
         bias = ((i / 100) % 2) ? 25 : 70;
         if ($urandom_range(99) < bias)
            code = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
         else if ($urandom_range(99) < 3)
            code = REQ_NONE;
         else
            code = 3'($urandom_range(REQ_DELETE, REQ_POP_FRONT));
         send_request(code, pick_key(), pick_value());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty-list cases, extremes, duplicates, missing keys, full store.
      send_request(REQ_POP_FRONT, '0, '0);
      send_request(REQ_POP_REAR, '0, '0);
      send_request(REQ_INS_AFTER, 32'd1, 32'd2);
      send_request(REQ_INS_BEFORE, 32'd1, 32'd2);
      send_request(REQ_DELETE, 32'd1, '0);
      send_request(REQ_NONE, 32'hffff_ffff, 32'hffff_ffff);
      send_request(REQ_PUSH_FRONT, '0, 32'h8000_0000);
      send_request(REQ_PUSH_REAR, '0, 32'h7fff_ffff);
      send_request(REQ_PUSH_REAR, '0, 32'hffff_ffff);
      send_request(REQ_PUSH_FRONT, '0, 32'hffff_ffff);
      send_request(REQ_INS_AFTER, 32'hffff_ffff, 32'd5);
      send_request(REQ_INS_BEFORE, 32'hffff_ffff, 32'd6);
      send_request(REQ_INS_AFTER, 32'h7fff_ffff, 32'd7);
      send_request(REQ_INS_BEFORE, 32'h8000_0000, 32'd8);
      send_request(REQ_DELETE, 32'hffff_ffff, '0);
      send_request(REQ_DELETE, 32'h1234_5678, '0);
      send_request(REQ_POP_FRONT, '0, '0);
      send_request(REQ_POP_REAR, '0, '0);
      // Fill the store to capacity, then ask for more.
      for (int i = 0; i < Capacity; i++) send_request(REQ_PUSH_REAR, '0, i);
      send_request(REQ_PUSH_FRONT, '0, 32'd1);
      send_request(REQ_INS_AFTER, 32'd3, 32'd1);
      send_request(REQ_INS_BEFORE, 32'h5555_5555, 32'd1);
      // A long search to the far end.
      send_request(REQ_DELETE, 32'd63, '0);
      send_request(REQ_INS_BEFORE, 32'd62, 32'haaaa_aaaa);

      random_phase(450);
      send_idle = 58;
      recv_idle = 13;
      random_phase(450);
      send_idle = 0;
      recv_idle = 0;
      random_phase(450);
      req.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // End of run: drain outstanding responses, then allow a short settling time.
   initial begin
      wait (stim_done);
      while (board.pending_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog: the slowest correct run is far below this bound.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
